// File: hdl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared widths, sizes and outcome codes for the TLB / page table translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    localparam int PAGE_W     = 8;
    localparam int FRAME_W    = 8;
    localparam int OFFSET_W   = 8;
    localparam int NUM_PAGES  = 256;
    localparam int NUM_FRAMES = 256;
    localparam int TLB_N      = 16;
    localparam int TLB_IDX_W  = 4;
    localparam int FCNT_W     = 9;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;

    // outcome codes
    localparam logic [1:0] OUT_TLB_HIT = 2'd0;
    localparam logic [1:0] OUT_PT_HIT  = 2'd1;
    localparam logic [1:0] OUT_FAULT   = 2'd2;

endpackage

// File: hdl/tlbpt_ram.sv
// ----------------------------------------------------------------------------
// tlbpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/tlb_page_table_lru_translator_core.sv
// ----------------------------------------------------------------------------
// tlb_page_table_lru_translator_core
// Virtual to physical translation with a 16-entry TLB, a page table and
// demand paging over 256 frames under LRU replacement.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. After ST_LOOK the sequencer steps
// through ST_MF0, ST_MF1 and ST_MF2 on a TLB or page table hit (to ST_TLB
// from ST_MF0 when the frame is already the most recent), ST_MAP and ST_INS
// on a fault on a free frame, and ST_EVICT, ST_MAP and ST_MF0 to ST_MF2 on a
// fault that evicts a mapped page; ST_TLB then sets the result. The result
// waits for m_tready, and the block is ready again in the cycle after the
// result transaction. Frame recency is a doubly linked list held in two
// RAMs; frames are handed out from 0 upward until all are in use, after
// which the list tail is the victim. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module tlb_page_table_lru_translator_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // virtual_page, page_offset, opcode (from bit 0 up)
    input  logic [tlbpt_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // physical_address, outcome, writeback_needed, writeback_page,
    // victim_had_page (from bit 0 up)
    output logic [tlbpt_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready
);

    import tlbpt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOOK, ST_EVICT, ST_MAP, ST_INS,
        ST_MF0, ST_MF1, ST_MF2, ST_TLB, ST_OUT
    } state_t;

    state_t state_reg;

    // transaction registers
    logic [PAGE_W-1:0]   pg_reg;
    logic [OFFSET_W-1:0] off_reg;
    logic                wr_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic [1:0]          outcome_reg;
    logic                wb_need_reg;
    logic [PAGE_W-1:0]   wb_page_reg;
    logic                had_reg;

    // tlb
    logic                 tlb_valid_reg [TLB_N];
    logic [PAGE_W-1:0]    tlb_page_reg  [TLB_N];
    logic [FRAME_W-1:0]   tlb_frame_reg [TLB_N];
    logic [TLB_IDX_W-1:0] tlb_rec_reg   [TLB_N];

    // per page and per frame flags
    logic [NUM_PAGES-1:0]  page_valid_reg;
    logic [NUM_FRAMES-1:0] dirty_reg;

    // frame lru list
    logic [FCNT_W-1:0]  fcnt_reg;
    logic [FRAME_W-1:0] head_reg;
    logic [FRAME_W-1:0] tail_reg;

    // memory ports
    logic               pf_we, own_we, nxt_we, prv_we;
    logic [PAGE_W-1:0]  pf_raddr;
    logic [FRAME_W-1:0] pf_rd, own_rd, nxt_rd, prv_rd;
    logic [FRAME_W-1:0] nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;

    // tlb lookup
    logic                 tlb_hit;
    logic [TLB_IDX_W-1:0] tlb_hit_idx;
    logic [TLB_IDX_W-1:0] touch_slot;
    logic [TLB_IDX_W-1:0] touch_pos;
    logic [TLB_IDX_W-1:0] tlb_rec_moved [TLB_N];

    assign s_tready = (state_reg == ST_IDLE);
    assign pf_raddr = s_tdata[PAGE_W-1:0];

    // fully associative compare, lowest slot wins
    always_comb begin
        tlb_hit     = 1'b0;
        tlb_hit_idx = '0;
        for (int i = TLB_N - 1; i >= 0; i--) begin
            if (tlb_valid_reg[i] && tlb_page_reg[i] == pg_reg) begin
                tlb_hit     = 1'b1;
                tlb_hit_idx = TLB_IDX_W'(i);
            end
        end
    end

    // tlb move-to-front of one slot
    always_comb begin
        touch_slot = (state_reg == ST_TLB) ? tlb_rec_reg[TLB_N-1] : tlb_hit_idx;
        touch_pos  = TLB_IDX_W'(TLB_N - 1);
        for (int j = TLB_N - 1; j >= 0; j--) begin
            if (tlb_rec_reg[j] == touch_slot) begin
                touch_pos = TLB_IDX_W'(j);
            end
        end
        tlb_rec_moved[0] = touch_slot;
        for (int j = 1; j < TLB_N; j++) begin
            tlb_rec_moved[j] = (TLB_IDX_W'(j) <= touch_pos) ? tlb_rec_reg[j-1]
                                                             : tlb_rec_reg[j];
        end
    end

    // memory write control
    always_comb begin
        pf_we     = (state_reg == ST_MAP);
        own_we    = (state_reg == ST_MAP);
        nxt_we    = 1'b0;
        nxt_waddr = frame_reg;
        nxt_wdata = head_reg;
        prv_we    = 1'b0;
        prv_waddr = head_reg;
        prv_wdata = frame_reg;
        unique case (state_reg)
            ST_MF1: begin
                nxt_we    = 1'b1;
                nxt_waddr = prv_rd;
                nxt_wdata = nxt_rd;
                prv_we    = (frame_reg != tail_reg);
                prv_waddr = nxt_rd;
                prv_wdata = prv_rd;
            end
            ST_MF2: begin
                nxt_we = 1'b1;
                prv_we = 1'b1;
            end
            ST_INS: begin
                nxt_we = (fcnt_reg != '0);
                prv_we = (fcnt_reg != '0);
            end
            default: begin
            end
        endcase
    end

    tlbpt_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_PAGES)) u_page_frame (
        .aclk(aclk), .wr_en(pf_we), .wr_addr(pg_reg), .wr_data(frame_reg),
        .rd_addr(pf_raddr), .rd_data(pf_rd)
    );

    tlbpt_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_FRAMES)) u_owner_page (
        .aclk(aclk), .wr_en(own_we), .wr_addr(frame_reg), .wr_data(pg_reg),
        .rd_addr(tail_reg), .rd_data(own_rd)
    );

    tlbpt_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_lru_next (
        .aclk(aclk), .wr_en(nxt_we), .wr_addr(nxt_waddr), .wr_data(nxt_wdata),
        .rd_addr(frame_reg), .rd_data(nxt_rd)
    );

    tlbpt_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_lru_prev (
        .aclk(aclk), .wr_en(prv_we), .wr_addr(prv_waddr), .wr_data(prv_wdata),
        .rd_addr(frame_reg), .rd_data(prv_rd)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid       <= 1'b0;
            fcnt_reg       <= '0;
            page_valid_reg <= '0;
            dirty_reg      <= '0;
            for (int i = 0; i < TLB_N; i++) begin
                tlb_valid_reg[i] <= 1'b0;
                tlb_rec_reg[i]   <= TLB_IDX_W'(i);
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        pg_reg    <= s_tdata[PAGE_W-1:0];
                        off_reg   <= s_tdata[PAGE_W +: OFFSET_W];
                        wr_reg    <= s_tdata[PAGE_W+OFFSET_W];
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    wb_need_reg <= 1'b0;
                    wb_page_reg <= '0;
                    had_reg     <= 1'b0;
                    if (tlb_hit) begin
                        frame_reg   <= tlb_frame_reg[tlb_hit_idx];
                        outcome_reg <= OUT_TLB_HIT;
                        tlb_rec_reg <= tlb_rec_moved;
                        state_reg   <= ST_MF0;
                    end else if (page_valid_reg[pg_reg]) begin
                        frame_reg   <= pf_rd;
                        outcome_reg <= OUT_PT_HIT;
                        state_reg   <= ST_MF0;
                    end else begin
                        outcome_reg <= OUT_FAULT;
                        if (fcnt_reg[FCNT_W-1]) begin
                            frame_reg <= tail_reg;
                            state_reg <= ST_EVICT;
                        end else begin
                            frame_reg <= fcnt_reg[FRAME_W-1:0];
                            state_reg <= ST_MAP;
                        end
                    end
                end
                ST_EVICT: begin
                    // unmap the victim's page and drop it from the tlb
                    had_reg                <= 1'b1;
                    wb_page_reg            <= own_rd;
                    wb_need_reg            <= dirty_reg[frame_reg];
                    page_valid_reg[own_rd] <= 1'b0;
                    for (int i = 0; i < TLB_N; i++) begin
                        if (tlb_page_reg[i] == own_rd) begin
                            tlb_valid_reg[i] <= 1'b0;
                        end
                    end
                    state_reg <= ST_MAP;
                end
                ST_MAP: begin
                    dirty_reg[frame_reg]   <= wr_reg;
                    page_valid_reg[pg_reg] <= 1'b1;
                    state_reg <= fcnt_reg[FCNT_W-1] ? ST_MF0 : ST_INS;
                end
                ST_INS: begin
                    // fresh frame goes to the head of the list
                    head_reg <= frame_reg;
                    if (fcnt_reg == '0) begin
                        tail_reg <= frame_reg;
                    end
                    fcnt_reg  <= fcnt_reg + 1'b1;
                    state_reg <= ST_TLB;
                end
                ST_MF0: begin
                    if (wr_reg) begin
                        dirty_reg[frame_reg] <= 1'b1;
                    end
                    state_reg <= (frame_reg == head_reg) ? ST_TLB : ST_MF1;
                end
                ST_MF1: begin
                    // unlink
                    if (frame_reg == tail_reg) begin
                        tail_reg <= prv_rd;
                    end
                    state_reg <= ST_MF2;
                end
                ST_MF2: begin
                    head_reg  <= frame_reg;
                    state_reg <= ST_TLB;
                end
                ST_TLB: begin
                    // load the least recent slot on a tlb miss
                    if (outcome_reg != OUT_TLB_HIT) begin
                        tlb_valid_reg[touch_slot] <= 1'b1;
                        tlb_page_reg[touch_slot]  <= pg_reg;
                        tlb_frame_reg[touch_slot] <= frame_reg;
                        tlb_rec_reg               <= tlb_rec_moved;
                    end
                    m_tdata <= {4'd0, had_reg, wb_page_reg, wb_need_reg,
                                outcome_reg, frame_reg, off_reg};
                    m_tvalid  <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_tready) begin
                        m_tvalid  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TLB / page table translator: drives accesses,
// keeps a behavioral copy of TLB, page table and frame LRU state, and checks
// every result transaction field by field against the predicted translation.
// ----------------------------------------------------------------------------
module tb;
    import tlbpt_pkg::*;

    typedef struct packed {
        logic [15:0] phys_addr;
        logic [1:0]  outcome;
        logic        wb_needed;
        logic [7:0]  wb_page;
        logic        victim_mapped;
    } xlat_t;

    logic                 aclk;
    logic                 aresetn;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready;

    // shadow translation state
    logic       tlb_v   [TLB_N];
    logic [7:0] tlb_pg  [TLB_N];
    logic [7:0] tlb_fr  [TLB_N];
    logic [3:0] tlb_mru [TLB_N];
    logic       pt_v    [NUM_PAGES];
    logic [7:0] pt_fr   [NUM_PAGES];
    logic       own_v   [NUM_FRAMES];
    logic [7:0] own_pg  [NUM_FRAMES];
    logic       dirty   [NUM_FRAMES];
    logic [7:0] fr_mru  [NUM_FRAMES];

    xlat_t xlat_q[$];
    int    mismatches;
    int    idle_cycles;
    int    burst_left;
    bit    timed_out;

    tlb_page_table_lru_translator_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // move frame to most recent position
    function automatic void frame_to_front(logic [7:0] f);
        int p;
        p = NUM_FRAMES - 1;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (fr_mru[i] == f) begin
                p = i;
                break;
            end
        end
        for (int i = p; i > 0; i--) fr_mru[i] = fr_mru[i-1];
        fr_mru[0] = f;
    endfunction

    function automatic void slot_to_front(logic [3:0] s);
        int p;
        p = TLB_N - 1;
        for (int i = 0; i < TLB_N; i++) begin
            if (tlb_mru[i] == s) begin
                p = i;
                break;
            end
        end
        for (int i = p; i > 0; i--) tlb_mru[i] = tlb_mru[i-1];
        tlb_mru[0] = s;
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < TLB_N; i++) begin
            tlb_v[i] = 1'b0;
            tlb_mru[i] = i[3:0];
        end
        for (int i = 0; i < NUM_PAGES; i++) pt_v[i] = 1'b0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            own_v[i] = 1'b0;
            dirty[i] = 1'b0;
            fr_mru[i] = 8'(NUM_FRAMES - 1 - i);
        end
    endfunction

    // translate one access and update the shadow state
    function automatic xlat_t translate(logic [7:0] pg, logic [7:0] off, logic wr);
        xlat_t r;
        logic [7:0] f;
        logic [7:0] old;
        logic [3:0] s;
        bit hit;
        r = '0;
        hit = 0;
        f = '0;
        for (int i = 0; i < TLB_N; i++) begin
            if (tlb_v[i] && tlb_pg[i] == pg) begin
                hit = 1;
                f = tlb_fr[i];
                if (wr) dirty[f] = 1'b1;
                frame_to_front(f);
                slot_to_front(4'(i));
                break;
            end
        end
        if (hit) begin
            r.outcome = OUT_TLB_HIT;
        end else begin
            if (pt_v[pg]) begin
                r.outcome = OUT_PT_HIT;
                f = pt_fr[pg];
            end else begin
                r.outcome = OUT_FAULT;
                f = fr_mru[NUM_FRAMES-1];
                if (own_v[f]) begin
                    old = own_pg[f];
                    r.victim_mapped = 1'b1;
                    r.wb_page = old;
                    r.wb_needed = dirty[f];
                    pt_v[old] = 1'b0;
                    for (int i = 0; i < TLB_N; i++)
                        if (tlb_v[i] && tlb_pg[i] == old) tlb_v[i] = 1'b0;
                end
                dirty[f] = 1'b0;
                own_v[f] = 1'b1;
                own_pg[f] = pg;
                pt_v[pg] = 1'b1;
                pt_fr[pg] = f;
            end
            if (wr) dirty[f] = 1'b1;
            frame_to_front(f);
            s = tlb_mru[TLB_N-1];
            tlb_v[s] = 1'b1;
            tlb_pg[s] = pg;
            tlb_fr[s] = f;
            slot_to_front(s);
        end
        r.phys_addr = {f, off};
        return r;
    endfunction

    // send one access, with bursty gaps between transactions
    task automatic send_access(logic [7:0] pg, logic [7:0] off, logic wr);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {7'd0, wr, off, pg};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        xlat_q.push_back(translate(pg, off, wr));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (xlat_q.size() != 0);
    endtask

    function automatic logic [7:0] rand_page(int span);
        return 8'($urandom_range(0, span - 1));
    endfunction

    // boundary pages and offsets, hits of both kinds
    task automatic test_directed();
        send_access(8'd0, 8'd0, 1'b0);
        send_access(8'd255, 8'd255, 1'b1);
        send_access(8'd0, 8'd255, 1'b1);
        send_access(8'd255, 8'd0, 1'b0);
        // push page 0 out of the TLB so it returns as a page table hit
        for (int i = 1; i <= 16; i++) send_access(8'(i), 8'(i * 15), 1'(i & 1));
        send_access(8'd0, 8'h5a, 1'b0);
        send_access(8'd255, 8'ha5, 1'b1);
        send_access(8'd170, 8'h0f, 1'b0);
        wait_drained();
    endtask

    // fault in pages from 17 upward, mixed with random pages across all 256
    task automatic test_eviction();
        for (int i = 0; i < 230; i++) begin
            if ($urandom_range(0, 9) < 7)
                send_access(8'(i + 17), 8'($urandom), 1'($urandom));
            else
                send_access(rand_page(256), 8'($urandom), 1'($urandom));
        end
        wait_drained();
    endtask

    // mix of a small hot set, wider working sets and random pages
    task automatic test_random();
        int mode;
        for (int i = 0; i < 150; i++) begin
            mode = $urandom_range(0, 9);
            if (mode < 4)
                send_access(rand_page(12), 8'($urandom), 1'($urandom));
            else if (mode < 7)
                send_access(rand_page(40), 8'($urandom), 1'($urandom));
            else
                send_access(rand_page(256), 8'($urandom), 1'($urandom));
            if (i == 75) wait_drained();
        end
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            case ($urandom_range(0, 3))
                0: m_tready <= 1'b0;
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // result checker
    always @(posedge aclk) begin
        xlat_t got;
        xlat_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[15:0], m_tdata[17:16], m_tdata[18], m_tdata[26:19],
                   m_tdata[27]};
            if (xlat_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction %h", m_tdata);
            end else begin
                exp_r = xlat_q.pop_front();
                if (got !== exp_r || m_tdata[31:28] !== 4'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp pa=%h oc=%0d wb=%0b wbp=%h had=%0b,",
                                  " got pa=%h oc=%0d wb=%0b wbp=%h had=%0b"},
                                 exp_r.phys_addr, exp_r.outcome, exp_r.wb_needed,
                                 exp_r.wb_page, exp_r.victim_mapped, got.phys_addr,
                                 got.outcome, got.wb_needed, got.wb_page, got.victim_mapped);
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000 && !timed_out) begin
            timed_out = 1;
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        idle_cycles = 0;
        burst_left = 0;
        timed_out = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        clear_shadow();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_eviction();
        test_random();
        wait_drained();
        repeat (30) @(posedge aclk);
        if (mismatches == 0 && xlat_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// File: tlb_page_table_lru_translator_core.f
hdl/tlbpt_pkg.sv
hdl/tlbpt_ram.sv
hdl/tlb_page_table_lru_translator_core.sv
tb/tb.sv
